@@ src/psd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants for the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int DIST_W = 25;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {
        REG_BEYOND_B = 2'd0,
        REG_BEFORE_A = 2'd1,
        REG_PERP     = 2'd2,
        REG_DEGEN    = 2'd3
    } region_t;

    typedef struct packed {
        logic    valid;
        region_t region;
    } ctl_t;

endpackage
// ----------------------------------------------------------------------------

@@ src/psd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_front
// Differences, products, dot and cross sums, case selection: four stages.
// ----------------------------------------------------------------------------
module psd_front #(
    parameter int COORD_WIDTH = 24,
    parameter int DW          = 25
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   in_valid,
    input  logic [COORD_WIDTH-1:0] a_x,
    input  logic [COORD_WIDTH-1:0] a_y,
    input  logic [COORD_WIDTH-1:0] b_x,
    input  logic [COORD_WIDTH-1:0] b_y,
    input  logic [COORD_WIDTH-1:0] e_x,
    input  logic [COORD_WIDTH-1:0] e_y,
    output psd_pkg::ctl_t          ctl,
    output logic [2*DW-1:0]        sq,
    output logic [2*DW-1:0]        mag
);

    localparam int EW = DW - 1;
    localparam int PW = 2 * DW + 1;
    localparam int MW = 2 * DW;

    logic signed [DW-1:0] ax_s, ay_s, bx_s, by_s, ex_s, ey_s;

    // stage 1
    logic                 v1_reg;
    logic signed [DW-1:0] abx_reg, aby_reg, bex_reg, bey_reg, aex_reg, aey_reg;
    // stage 2
    logic                 v2_reg;
    logic                 abz2_reg;
    logic signed [MW-1:0] dbx_reg, dby_reg, dax_reg, day_reg, c1_reg, c2_reg;
    logic signed [MW-1:0] sbx_reg, sby_reg, sax_reg, say_reg, sabx_reg, saby_reg;
    // stage 3
    logic                 v3_reg;
    logic                 abz3_reg;
    logic signed [PW-1:0] dot_be_reg, dot_ae_reg, cross_reg;
    logic [MW-1:0]        sq_be_reg, sq_ae_reg, sq_ab_reg;
    // stage 4
    psd_pkg::ctl_t        ctl_reg, ctl_next;
    logic [MW-1:0]        sq_reg, sq_next, mag_reg, mag_next;

    // ignore bits above the effective coordinate width
    assign ax_s = {a_x[EW-1], a_x[EW-1:0]};
    assign ay_s = {a_y[EW-1], a_y[EW-1:0]};
    assign bx_s = {b_x[EW-1], b_x[EW-1:0]};
    assign by_s = {b_y[EW-1], b_y[EW-1:0]};
    assign ex_s = {e_x[EW-1], e_x[EW-1:0]};
    assign ey_s = {e_y[EW-1], e_y[EW-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            abx_reg <= bx_s - ax_s;
            aby_reg <= by_s - ay_s;
            bex_reg <= ex_s - bx_s;
            bey_reg <= ey_s - by_s;
            aex_reg <= ex_s - ax_s;
            aey_reg <= ey_s - ay_s;

            abz2_reg <= (abx_reg == '0) && (aby_reg == '0);
            dbx_reg  <= abx_reg * bex_reg;
            dby_reg  <= aby_reg * bey_reg;
            dax_reg  <= abx_reg * aex_reg;
            day_reg  <= aby_reg * aey_reg;
            c1_reg   <= abx_reg * aey_reg;
            c2_reg   <= aby_reg * aex_reg;
            sbx_reg  <= bex_reg * bex_reg;
            sby_reg  <= bey_reg * bey_reg;
            sax_reg  <= aex_reg * aex_reg;
            say_reg  <= aey_reg * aey_reg;
            sabx_reg <= abx_reg * abx_reg;
            saby_reg <= aby_reg * aby_reg;

            abz3_reg   <= abz2_reg;
            dot_be_reg <= PW'(dbx_reg) + PW'(dby_reg);
            dot_ae_reg <= PW'(dax_reg) + PW'(day_reg);
            cross_reg  <= PW'(c1_reg) - PW'(c2_reg);
            sq_be_reg  <= $unsigned(sbx_reg) + $unsigned(sby_reg);
            sq_ae_reg  <= $unsigned(sax_reg) + $unsigned(say_reg);
            sq_ab_reg  <= $unsigned(sabx_reg) + $unsigned(saby_reg);

            sq_reg  <= sq_next;
            mag_reg <= mag_next;
        end
    end

    always_comb
    begin
        ctl_next.valid = v3_reg;
        if (!dot_be_reg[PW-1] && (dot_be_reg != '0))
        begin
            ctl_next.region = psd_pkg::REG_BEYOND_B;
            sq_next         = sq_be_reg;
        end
        else if (dot_ae_reg[PW-1])
        begin
            ctl_next.region = psd_pkg::REG_BEFORE_A;
            sq_next         = sq_ae_reg;
        end
        else if (abz3_reg)
        begin
            ctl_next.region = psd_pkg::REG_DEGEN;
            sq_next         = sq_ae_reg;
        end
        else
        begin
            ctl_next.region = psd_pkg::REG_PERP;
            sq_next         = sq_ab_reg;
        end
        mag_next = cross_reg[PW-1] ? MW'(-cross_reg) : MW'(cross_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (advance)
            ctl_reg <= ctl_next;
    end

    assign ctl = ctl_reg;
    assign sq  = sq_reg;
    assign mag = mag_reg;

endmodule
// ----------------------------------------------------------------------------

@@ src/psd_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt #(
    parameter int DW = 25
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  psd_pkg::ctl_t   ctl,
    input  logic [2*DW-1:0] sq,
    input  logic [2*DW-1:0] mag,
    output psd_pkg::ctl_t   ctl_out,
    output logic [DW-1:0]   root,
    output logic [2*DW-1:0] mag_out
);

    localparam int RW  = DW;
    localparam int SQW = 2 * DW;
    localparam int MW  = 2 * DW;
    localparam int RMW = RW + 3;

    psd_pkg::ctl_t    ctl_reg  [RW];
    logic [RMW-1:0]   rem_reg  [RW];
    logic [RW-1:0]    root_reg [RW];
    logic [SQW-1:0]   sq_reg   [RW];
    logic [MW-1:0]    mag_reg  [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_step
        psd_pkg::ctl_t  ctl_in;
        logic [RMW-1:0] rem_in, cur, trial, rem_next;
        logic [RW-1:0]  root_in, root_next;
        logic [SQW-1:0] sq_in;
        logic [MW-1:0]  mag_in;

        if (k == 0)
        begin : g_first
            assign ctl_in  = ctl;
            assign rem_in  = '0;
            assign root_in = '0;
            assign sq_in   = sq;
            assign mag_in  = mag;
        end
        else
        begin : g_rest
            assign ctl_in  = ctl_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign sq_in   = sq_reg[k-1];
            assign mag_in  = mag_reg[k-1];
        end

        // bring down the next pair of radicand bits
        assign cur   = {rem_in[RMW-3:0], sq_in[SQW-1-2*k -: 2]};
        assign trial = RMW'({root_in, 2'b01});

        always_comb
        begin
            if (cur >= trial)
            begin
                rem_next  = cur - trial;
                root_next = {root_in[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cur;
                root_next = {root_in[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[k] <= '0;
            else if (advance)
                ctl_reg[k] <= ctl_in;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                sq_reg[k]   <= sq_in;
                mag_reg[k]  <= mag_in;
            end
        end
    end

    assign ctl_out = ctl_reg[RW-1];
    assign root    = root_reg[RW-1];
    assign mag_out = mag_reg[RW-1];

endmodule
// ----------------------------------------------------------------------------

@@ src/psd_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_div
// Saturation check and pipelined restoring divide of the cross magnitude by
// the segment length, one quotient bit per stage; other regions pass the clamped root.
// ----------------------------------------------------------------------------
module psd_div #(
    parameter int DW = 25
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  psd_pkg::ctl_t              ctl,
    input  logic [DW-1:0]              root,
    input  logic [2*DW-1:0]            mag,
    output psd_pkg::ctl_t              ctl_out,
    output logic [psd_pkg::DIST_W-1:0] distance
);

    localparam int RW    = DW;
    localparam int MW    = 2 * DW;
    localparam int DISTW = psd_pkg::DIST_W;
    localparam int XW    = MW + DISTW;
    localparam int NS    = DISTW;

    psd_pkg::ctl_t    ctl0_reg;
    logic [MW-1:0]    rem0_reg;
    logic [RW-1:0]    len0_reg;
    logic [DISTW-1:0] q0_reg, q0_next;
    logic             done0_reg, done0_next;
    logic             sat;
    logic [DISTW-1:0] root_sat;

    psd_pkg::ctl_t    ctl_reg  [NS];
    logic [MW-1:0]    rem_reg  [NS];
    logic [RW-1:0]    len_reg  [NS];
    logic [DISTW-1:0] q_reg    [NS];
    logic             done_reg [NS];

    assign sat      = XW'(mag) >= (XW'(root) << DISTW);
    assign root_sat = (XW'(root) > XW'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX
                                                           : DISTW'(root);

    always_comb
    begin
        if (ctl.region == psd_pkg::REG_PERP)
        begin
            q0_next    = sat ? psd_pkg::DIST_MAX : '0;
            done0_next = sat;
        end
        else
        begin
            q0_next    = root_sat;
            done0_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl0_reg <= '0;
        else if (advance)
            ctl0_reg <= ctl;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem0_reg  <= mag;
            len0_reg  <= root;
            q0_reg    <= q0_next;
            done0_reg <= done0_next;
        end
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_step
        localparam int BIT = NS - 1 - j;
        psd_pkg::ctl_t    ctl_in;
        logic [MW-1:0]    rem_in, rem_next;
        logic [RW-1:0]    len_in;
        logic [DISTW-1:0] q_in, q_next;
        logic             done_in;
        logic [XW-1:0]    shifted;

        if (j == 0)
        begin : g_first
            assign ctl_in  = ctl0_reg;
            assign rem_in  = rem0_reg;
            assign len_in  = len0_reg;
            assign q_in    = q0_reg;
            assign done_in = done0_reg;
        end
        else
        begin : g_rest
            assign ctl_in  = ctl_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign len_in  = len_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign done_in = done_reg[j-1];
        end

        assign shifted = XW'(len_in) << BIT;

        always_comb
        begin
            if (!done_in && (XW'(rem_in) >= shifted))
            begin
                rem_next = rem_in - MW'(shifted);
                q_next   = q_in | (DISTW'(1) << BIT);
            end
            else
            begin
                rem_next = rem_in;
                q_next   = q_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[j] <= '0;
            else if (advance)
                ctl_reg[j] <= ctl_in;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[j]  <= rem_next;
                len_reg[j]  <= len_in;
                q_reg[j]    <= q_next;
                done_reg[j] <= done_in;
            end
        end
    end

    assign ctl_out  = ctl_reg[NS-1];
    assign distance = q_reg[NS-1];

endmodule
// ----------------------------------------------------------------------------

@@ src/point_segment_distance.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a query point to a line segment, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with end points a_x, a_y, b_x, b_y and
// query point e_x, e_y (signed Q8.16). Output channel: out_valid / out_stall
// with distance (unsigned Q9.16, saturating) and region (beyond B, before A,
// perpendicular, degenerate segment).
// One beat is taken every cycle while in_stall is low. DW is the effective
// coordinate width plus one. The pipeline is made of four front stages, one
// root stage per root bit, a saturation stage, one divide stage per distance
// bit and the output register.
// The whole pipeline advances together; it holds only while a result sits
// in the output register and out_stall is high, and in_stall is raised for
// exactly those cycles.
// Reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module point_segment_distance #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [COORD_WIDTH-1:0]     a_x,
    input  logic [COORD_WIDTH-1:0]     a_y,
    input  logic [COORD_WIDTH-1:0]     b_x,
    input  logic [COORD_WIDTH-1:0]     b_y,
    input  logic [COORD_WIDTH-1:0]     e_x,
    input  logic [COORD_WIDTH-1:0]     e_y,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [psd_pkg::DIST_W-1:0] distance,
    output logic [1:0]                 region
);

    localparam int EW = (COORD_WIDTH > 30) ? 30 : COORD_WIDTH;
    localparam int DW = EW + 1;

    logic                       advance;
    psd_pkg::ctl_t              front_ctl, sqrt_ctl, div_ctl;
    logic [2*DW-1:0]            front_sq, front_mag, sqrt_mag;
    logic [DW-1:0]              sqrt_root;
    logic [psd_pkg::DIST_W-1:0] div_dist;

    logic                       out_valid_reg;
    logic [psd_pkg::DIST_W-1:0] distance_reg;
    psd_pkg::region_t           region_reg;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    psd_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .DW          (DW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid),
        .a_x      (a_x),
        .a_y      (a_y),
        .b_x      (b_x),
        .b_y      (b_y),
        .e_x      (e_x),
        .e_y      (e_y),
        .ctl      (front_ctl),
        .sq       (front_sq),
        .mag      (front_mag)
    );

    psd_sqrt #(
        .DW (DW)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .ctl     (front_ctl),
        .sq      (front_sq),
        .mag     (front_mag),
        .ctl_out (sqrt_ctl),
        .root    (sqrt_root),
        .mag_out (sqrt_mag)
    );

    psd_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .ctl      (sqrt_ctl),
        .root     (sqrt_root),
        .mag      (sqrt_mag),
        .ctl_out  (div_ctl),
        .distance (div_dist)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= div_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            distance_reg <= div_dist;
            region_reg   <= div_ctl.region;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign region    = region_reg;

`ifndef SYNTH
    // back-pressure only ever comes from a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("in_stall raised with no result held");

    // a held pipeline keeps its last divide stage unchanged
    a_hold_div: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(div_ctl) && $stable(div_dist))
        else $error("pipeline moved while held");

    // a held result stays on the output
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(distance_reg))
        else $error("held result changed");
`endif

endmodule
// ----------------------------------------------------------------------------

@@ bench/psd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_checker
// Watches both channels of the point to segment distance block, works out
// the expected distance and region for every accepted query beat and
// compares them with each accepted result beat in order.
// ----------------------------------------------------------------------------
module psd_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [23:0]                a_x,
    input  logic [23:0]                a_y,
    input  logic [23:0]                b_x,
    input  logic [23:0]                b_y,
    input  logic [23:0]                e_x,
    input  logic [23:0]                e_y,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [psd_pkg::DIST_W-1:0] distance,
    input  logic [1:0]                 region,
    output int                         fail_count,
    output int                         pending_count,
    output int                         result_count,
    output int                         region_seen [4]
);

    typedef struct {
        logic [psd_pkg::DIST_W-1:0] dist_val;
        psd_pkg::region_t           reg_id;
    } answer_t;

    answer_t expected_answers[$];

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned bit_v;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (v >= r + bit_v)
            begin
                v -= r + bit_v;
                r = (r >> 1) + bit_v;
            end
            else
                r >>= 1;
            bit_v >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned span(longint dx, longint dy);
        return floor_root(longint'(dx * dx) + longint'(dy * dy));
    endfunction

    function automatic answer_t nearest_distance(logic [23:0] ax_r, logic [23:0] ay_r,
                                                 logic [23:0] bx_r, logic [23:0] by_r,
                                                 logic [23:0] ex_r, logic [23:0] ey_r);
        longint ax, ay, bx, by, ex, ey;
        longint abx, aby, bex, bey, aex, aey, dot_b, dot_a, cr;
        longint unsigned d, mag, len;
        answer_t ans;
        ax = longint'($signed(ax_r)); ay = longint'($signed(ay_r));
        bx = longint'($signed(bx_r)); by = longint'($signed(by_r));
        ex = longint'($signed(ex_r)); ey = longint'($signed(ey_r));
        abx = bx - ax; aby = by - ay;
        bex = ex - bx; bey = ey - by;
        aex = ex - ax; aey = ey - ay;
        dot_b = abx * bex + aby * bey;
        dot_a = abx * aex + aby * aey;
        if (dot_b > 0)
        begin
            d = span(bex, bey);
            ans.reg_id = psd_pkg::REG_BEYOND_B;
        end
        else if (dot_a < 0)
        begin
            d = span(aex, aey);
            ans.reg_id = psd_pkg::REG_BEFORE_A;
        end
        else if (abx == 0 && aby == 0)
        begin
            d = span(aex, aey);
            ans.reg_id = psd_pkg::REG_DEGEN;
        end
        else
        begin
            cr = abx * aey - aby * aex;
            mag = cr < 0 ? longint'(-cr) : cr;
            len = span(abx, aby);
            d = (len != 0) ? mag / len : 0;
            ans.reg_id = psd_pkg::REG_PERP;
        end
        ans.dist_val = (d > psd_pkg::DIST_MAX) ? psd_pkg::DIST_MAX
                                               : d[psd_pkg::DIST_W-1:0];
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            expected_answers.delete();
            fail_count <= 0;
            result_count <= 0;
            for (int i = 0; i < 4; i++)
                region_seen[i] <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_answers.insert(expected_answers.size(),
                    nearest_distance(a_x, a_y, b_x, b_y, e_x, e_y));
            if (out_valid && !out_stall)
            begin
                result_count <= result_count + 1;
                region_seen[region] <= region_seen[region] + 1;
                if (expected_answers.size() == 0)
                begin
                    $error("unexpected result beat: distance %0d region %0d",
                           distance, region);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (distance !== want.dist_val || region !== want.reg_id)
                    begin
                        if (distance !== want.dist_val)
                            $error("distance: expected %0d, got %0d",
                                   want.dist_val, distance);
                        if (region !== want.reg_id)
                            $error("region: expected %0d, got %0d", want.reg_id, region);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    assign pending_count = expected_answers.size();

endmodule
// ----------------------------------------------------------------------------

@@ bench/tb_point_segment_distance.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_segment_distance
// Drives directed and random segment queries through the distance block
// under three idling patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_point_segment_distance;

    localparam int LATENCY   = 56;
    localparam int WATCHDOG  = 20000;
    localparam int RAND_BEATS = 2000;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [23:0]                a_x, a_y, b_x, b_y, e_x, e_y;
    logic                       out_valid;
    logic                       out_stall;
    logic [psd_pkg::DIST_W-1:0] distance;
    logic [1:0]                 region;
    int                         fail_count;
    int                         pending_count;
    int                         result_count;
    int                         region_seen [4];
    int                         send_idle_pct;
    int                         recv_idle_pct;
    int                         quiet_cycles;
    bit                         timed_out;

    point_segment_distance #(.COORD_WIDTH(24)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y), .e_x(e_x), .e_y(e_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .distance(distance), .region(region)
    );

    psd_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y), .e_x(e_x), .e_y(e_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .distance(distance), .region(region),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count), .region_seen(region_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver stalls at random, rate set per phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d results outstanding", pending_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [23:0] rand_coord(int spread);
        case (spread)
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(8191)) - 4096);
            default: return 24'($signed($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    // present one query beat and hold it until taken
    task automatic send_query(logic [23:0] ax, logic [23:0] ay, logic [23:0] bx,
                              logic [23:0] by, logic [23:0] ex, logic [23:0] ey);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        a_x <= ax; a_y <= ay; b_x <= bx; b_y <= by; e_x <= ex; e_y <= ey;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic directed_queries();
        logic [23:0] mx, mn, zr, one;
        mx = 24'h7fffff;
        mn = 24'h800000;
        zr = 24'd0;
        one = 24'd1;
        send_query(zr, zr, 24'h10000, zr, 24'h20000, 24'h5000);     // past B
        send_query(zr, zr, 24'h10000, zr, -24'sh8000, 24'h3000);    // before A
        send_query(zr, zr, 24'h10000, zr, 24'h8000, 24'h3000);      // perpendicular
        send_query(24'h1234, 24'h5678, 24'h1234, 24'h5678, mx, mn); // zero length
        send_query(mn, mn, mn, mn, mx, mx);
        send_query(mx, mx, mx, mx, mn, mn);
        send_query(mn, mn, mx, mx, mx, mn);
        send_query(mn, mx, mx, mn, zr, zr);
        send_query(mx, mn, mn, mx, mn, mn);
        send_query(zr, zr, one, zr, zr, mx);                        // tiny AB, big quotient
        send_query(zr, zr, one, one, mn, mx);
        send_query(zr, zr, zr, zr, zr, zr);
        send_query(zr, zr, 24'h10000, zr, 24'h10000, 24'h1000);     // E above B exactly
        send_query(zr, zr, 24'h10000, zr, zr, 24'h1000);            // E above A exactly
        send_query(24'hffffff, 24'hffffff, zr, zr, 24'haaaaaa, 24'h555555);
        send_query(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555, mx, mx);
    endtask

    task automatic random_queries(int count);
        logic [23:0] ax, ay, bx, by;
        int spread;
        for (int i = 0; i < count; i++)
        begin
            spread = $urandom_range(2);
            ax = rand_coord(spread);
            ay = rand_coord(spread);
            case ($urandom_range(9))
                0: begin bx = ax; by = ay; end
                1:
                begin
                    bx = ax + 24'($urandom_range(2));
                    by = ay + 24'($urandom_range(2));
                end
                default: begin bx = rand_coord(spread); by = rand_coord(spread); end
            endcase
            send_query(ax, ay, bx, by, rand_coord(spread), rand_coord(spread));
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        a_x = '0; a_y = '0; b_x = '0; b_y = '0; e_x = '0; e_y = '0;
        send_idle_pct = 10;
        recv_idle_pct = 61;
        timed_out = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_queries();
        random_queries(RAND_BEATS / 3);
        send_idle_pct = 61;
        recv_idle_pct = 10;
        random_queries(RAND_BEATS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_queries(RAND_BEATS / 3);
        drain();

        $display("%0d results checked over three idling patterns", result_count);
        $display("regions seen: beyond B %0d, before A %0d, perpendicular %0d,",
                 region_seen[0], region_seen[1], region_seen[2]);
        $display("              zero length %0d", region_seen[3]);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
// ----------------------------------------------------------------------------

@@ files.f @@
src/psd_pkg.sv
src/psd_front.sv
src/psd_sqrt.sv
src/psd_div.sv
src/point_segment_distance.sv
bench/psd_checker.sv
bench/tb_point_segment_distance.sv
